>>> hdl/spq_pkg.sv
// Shared types, codes and defaults for the stable priority queue.
package spq_pkg;

  // Default number of cells in the chain.
  localparam int DEFAULT_DEPTH = 16;

  // Width of the fill level seen on the response channel.
  localparam int FILL_W = 5;

  // Operation codes on the request channel.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REMOVED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // One stored entry.
  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  kind;
    logic [3:0]  prio;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } cell_op_t;

  // What one cell shows to its neighbours.
  typedef struct packed {
    logic   vld;
    logic   keep;
    entry_t ent;
  } cell_link_t;

endpackage

>>> hdl/spq_if.sv
// Request and response channel interfaces of the stable priority queue.
interface spq_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] entry_code;
  logic [7:0]  entry_kind;
  logic [3:0]  entry_priority;

  modport source (output valid, mode, entry_code, entry_kind, entry_priority, input ready);
  modport sink   (input valid, mode, entry_code, entry_kind, entry_priority, output ready);
endinterface

interface spq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_code;
  logic [7:0]  out_kind;
  logic [3:0]  out_priority;
  logic [4:0]  fill_level;

  modport source (output valid, status, out_code, out_kind, out_priority, fill_level,
                  input ready);
  modport sink   (input valid, status, out_code, out_kind, out_priority, fill_level,
                  output ready);
endinterface

>>> hdl/spq_cell.sv
// One cell of the sorted chain: holds a single entry and its valid flag.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_op_t   op,
  input  cell_link_t prev,
  input  cell_link_t next,
  output cell_link_t self
);

  logic   vld;
  entry_t ent;
  logic   keep;

  // The cell holds its entry on insert when it sorts at or before the new one.
  assign keep = vld && (ent.prio <= op.ent.prio);

  assign self.vld  = vld;
  assign self.keep = keep;
  assign self.ent  = ent;

  // Valid flag: insert shifts down behind the new entry, remove shifts up.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (op.ins) begin
      if (!keep) begin
        vld <= prev.keep ? 1'b1 : prev.vld;
      end
    end else if (op.rem) begin
      vld <= next.vld;
    end
  end

  // Entry payload follows the same moves and needs no reset.
  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (!keep) begin
        ent <= prev.keep ? op.ent : prev.ent;
      end
    end else if (op.rem) begin
      ent <= next.ent;
    end
  end

endmodule

>>> hdl/stable_priority_queue_top.sv
// Top level of the stable priority queue: a chain of sorting cells and a response register.
//
//   channel | role  | payload
//   --------+-------+------------------------------------------------------------
//   req     | sink  | mode, entry_code, entry_kind, entry_priority
//   rsp     | source| status, out_code, out_kind, out_priority, fill_level
//
// Every cell compares its priority with the broadcast entry and moves in the
// same edge, so one insert or remove is done per clock unless a stalled response
// holds the request side. The response appears in the cycle after acceptance.
// A new request is taken whenever the response register is empty or is being
// drained in the same cycle; a stalled response holds the request side.
// Reset (synchronous, active high) empties the chain and the response register.
module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
  input logic      clk,
  input logic      rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic             accept;
  logic             full;
  logic             empty;
  cell_op_t         op;
  entry_t           new_ent;
  cell_link_t       links [QUEUE_DEPTH];
  cell_link_t       edge_prev;
  cell_link_t       edge_next;

  assign full   = (count == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign accept = req.valid && req.ready;

  // Request side stalls only while an unread response is held.
  assign req.ready = !rsp.valid || rsp.ready;

  assign new_ent.code = req.entry_code;
  assign new_ent.kind = req.entry_kind;
  assign new_ent.prio = req.entry_priority;

  // Operation broadcast to the chain; refused operations move nothing.
  assign op.ins = accept && (req.mode == MODE_INSERT) && !full;
  assign op.rem = accept && (req.mode == MODE_REMOVE) && !empty;
  assign op.ent = new_ent;

  // The head cell sees a neighbour that always keeps; the tail sees an empty one.
  assign edge_prev = '{vld: 1'b0, keep: 1'b1, ent: '0};
  assign edge_next = '{vld: 1'b0, keep: 1'b0, ent: '0};

  // Chain of cells.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_link_t prev_link;
    cell_link_t next_link;

    if (i == 0) begin : g_head
      assign prev_link = edge_prev;
    end else begin : g_body
      assign prev_link = links[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_link = edge_next;
    end else begin : g_mid
      assign next_link = links[i+1];
    end

    spq_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .op   (op),
      .prev (prev_link),
      .next (next_link),
      .self (links[i])
    );
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op.ins) begin
      count <= count + 1'b1;
    end else if (op.rem) begin
      count <= count - 1'b1;
    end
  end

  // Response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Response payload, loaded with each accepted transaction.
  // Entry fields carry the head entry on a removal and zero otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.out_code     <= op.rem ? links[0].ent.code : '0;
      rsp.out_kind     <= op.rem ? links[0].ent.kind : '0;
      rsp.out_priority <= op.rem ? links[0].ent.prio : '0;
      if (req.mode == MODE_INSERT) begin
        rsp.status     <= full ? ST_FULL : ST_INSERTED;
        rsp.fill_level <= full ? FILL_W'(count) : FILL_W'(count + 1'b1);
      end else if (empty) begin
        rsp.status     <= ST_EMPTY;
        rsp.fill_level <= FILL_W'(count);
      end else begin
        rsp.status     <= ST_REMOVED;
        rsp.fill_level <= FILL_W'(count - 1'b1);
      end
    end
  end

endmodule

>>> hdl/spq_checker.sv
// Port-level checks for the stable priority queue and their binding to the top level.
module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [15:0] out_code,
  input logic [7:0]  out_kind,
  input logic [3:0]  out_priority,
  input logic [4:0]  fill_level
);

  localparam logic [4:0] FULL_LEVEL = 5'(QUEUE_DEPTH);

  // Only a removal carries entry fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_REMOVED) |->
      (out_code == '0) && (out_kind == '0) && (out_priority == '0))
    else $error("entry fields not zero on a non-removal response");

  // A remove on an empty queue reports a level of zero.
  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY) |-> (fill_level == '0))
    else $error("empty status with non-zero fill level");

  // A refused insert reports a full queue.
  a_full_level: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> (fill_level == FULL_LEVEL))
    else $error("full status without a full fill level");

  // A stalled response holds its status, code and fill level.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(status) && $stable(out_code) && $stable(fill_level))
    else $error("stalled response changed");

endmodule

bind stable_priority_queue_top spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .out_code     (rsp.out_code),
  .out_kind     (rsp.out_kind),
  .out_priority (rsp.out_priority),
  .fill_level   (rsp.fill_level)
);
